FILE: hdl/pct_pkg.sv
// types and constants shared by the peer connection table modules
package pct_pkg;

  typedef enum logic [1:0] {
    ST_FREE        = 2'd0,
    ST_HANDSHAKING = 2'd1,
    ST_JOINED      = 2'd2,
    ST_LEAVING     = 2'd3
  } slot_st_e;

  typedef enum logic [2:0] {
    OP_LINK_UP      = 3'd0,
    OP_LINK_DOWN    = 3'd1,
    OP_MARK_JOINED  = 3'd2,
    OP_MARK_LEAVING = 3'd3,
    OP_FIND_LINK    = 3'd4,
    OP_FIND_PEER    = 3'd5,
    OP_NOP          = 3'd7
  } op_e;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [31:0] link_id;
    logic [15:0] peer_id;
    logic [7:0]  minor_version;
  } req_t;

  typedef struct packed {
    logic        ok;
    logic [3:0]  slot_index;
    logic [1:0]  slot_state;
    logic [31:0] found_link;
    logic [15:0] found_peer;
    logic [7:0]  found_minor;
    logic [4:0]  joined_count;
    logic [4:0]  occupied_count;
  } rsp_t;

  typedef struct packed {
    op_e         op;
    logic [31:0] link;
    logic [15:0] peer;
    logic [7:0]  minor;
  } cmd_t;

  typedef struct packed {
    slot_st_e    st;
    logic [31:0] link;
    logic [15:0] peer;
    logic [7:0]  minor;
  } entry_t;

endpackage

FILE: hdl/pct_front.sv
// front end: accepts transactions, decodes the opcode and queues commands
module pct_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  pct_pkg::req_t in_data_i,
  output logic          cmd_valid_o,
  output pct_pkg::cmd_t cmd_o,
  input  logic          cmd_pop_i
);
  import pct_pkg::*;

  localparam int QDepth = 2;

  cmd_t       q_mem [QDepth];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  cmd_t       dec;
  logic       push, pop;

  always_comb begin
    unique case (in_data_i.opcode)
      OP_LINK_UP:      dec.op = OP_LINK_UP;
      OP_LINK_DOWN:    dec.op = OP_LINK_DOWN;
      OP_MARK_JOINED:  dec.op = OP_MARK_JOINED;
      OP_MARK_LEAVING: dec.op = OP_MARK_LEAVING;
      OP_FIND_LINK:    dec.op = OP_FIND_LINK;
      OP_FIND_PEER:    dec.op = OP_FIND_PEER;
      default:         dec.op = OP_NOP;
    endcase
    dec.link  = in_data_i.link_id;
    dec.peer  = in_data_i.peer_id;
    dec.minor = in_data_i.minor_version;
  end

  assign in_stall_o  = (cnt_q == 2'(QDepth));
  assign push        = in_valid_i && !in_stall_o;
  assign pop         = cmd_pop_i && (cnt_q != 2'd0);
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = q_mem[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem[wr_ptr_q] <= dec;
    end
  end

endmodule

FILE: hdl/pct_back.sv
// back end: scans the slot memory, applies the command and registers the result
module pct_back #(
  parameter int SLOTS = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cmd_valid_i,
  input  pct_pkg::cmd_t cmd_i,
  output logic          cmd_pop_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output pct_pkg::rsp_t out_data_o
);
  import pct_pkg::*;

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(SLOTS + 1);

  typedef enum logic [3:0] {
    BK_IDLE  = 4'b0001,
    BK_SCAN  = 4'b0010,
    BK_DRAIN = 4'b0100,
    BK_EXEC  = 4'b1000
  } back_st_e;

  back_st_e        st_q, st_d;
  entry_t          mem [SLOTS];
  logic [SLOTS-1:0] vld_q, vld_d;
  cmd_t            cur_q, cur_d;
  logic [IW-1:0]   cnt_q, cnt_d;
  entry_t          rd_q;
  logic            rv_q;
  logic [IW-1:0]   rdi_q;
  logic            rdp_q, rdp_d;
  logic            hit_q, hit_d;
  logic [IW-1:0]   hidx_q, hidx_d;
  entry_t          hent_q, hent_d;
  logic            free_q, free_d;
  logic [IW-1:0]   fidx_q, fidx_d;
  logic [CW-1:0]   joined_q, joined_d;
  logic [CW-1:0]   occ_q, occ_d;
  logic            out_valid_q, out_valid_d;
  rsp_t            out_q, out_d;
  slot_st_e        rst_st;
  logic            link_m, peer_m, key_m;
  logic            fire, ok, we;
  logic [IW-1:0]   idx;
  entry_t          ent;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign fire        = (st_q == BK_EXEC) && (!out_valid_q || !out_stall_i);
  assign cmd_pop_o   = (st_q == BK_IDLE) && cmd_valid_i;

  // match check on the entry read in the previous cycle
  always_comb begin
    rst_st = rv_q ? rd_q.st : ST_FREE;
    link_m = (rst_st != ST_FREE) && (rd_q.link == cur_q.link);
    peer_m = ((rst_st == ST_JOINED) || (rst_st == ST_LEAVING)) &&
             (rd_q.peer == cur_q.peer);
    key_m  = (cur_q.op == OP_FIND_PEER) ? peer_m : link_m;
  end

  always_comb begin
    st_d   = st_q;
    cur_d  = cur_q;
    cnt_d  = cnt_q;
    rdp_d  = 1'b0;
    hit_d  = hit_q;
    hidx_d = hidx_q;
    hent_d = hent_q;
    free_d = free_q;
    fidx_d = fidx_q;

    if (rdp_q) begin
      if (key_m && !hit_q) begin
        hit_d     = 1'b1;
        hidx_d    = rdi_q;
        hent_d    = rd_q;
        hent_d.st = rst_st;
      end
      if ((rst_st == ST_FREE) && !free_q) begin
        free_d = 1'b1;
        fidx_d = rdi_q;
      end
    end

    unique case (st_q)
      BK_IDLE: begin
        if (cmd_valid_i) begin
          cur_d  = cmd_i;
          cnt_d  = '0;
          hit_d  = 1'b0;
          free_d = 1'b0;
          st_d   = BK_SCAN;
        end
      end
      BK_SCAN: begin
        rdp_d = 1'b1;
        cnt_d = cnt_q + IW'(1);
        if (cnt_q == IW'(SLOTS - 1)) begin
          st_d = BK_DRAIN;
        end
      end
      BK_DRAIN: begin
        st_d = BK_EXEC;
      end
      BK_EXEC: begin
        if (fire) begin
          st_d = BK_IDLE;
        end
      end
      default: st_d = BK_IDLE;
    endcase
  end

  always_comb begin
    ok       = 1'b0;
    we       = 1'b0;
    idx      = hidx_q;
    ent      = hent_q;
    vld_d    = vld_q;
    joined_d = joined_q;
    occ_d    = occ_q;

    case (cur_q.op) inside
      OP_LINK_UP: begin
        if (hit_q) begin
          ok = 1'b1;
        end else if (free_q) begin
          ok        = 1'b1;
          we        = 1'b1;
          idx       = fidx_q;
          ent.st    = ST_HANDSHAKING;
          ent.link  = cur_q.link;
          ent.peer  = '0;
          ent.minor = '0;
          vld_d[fidx_q] = 1'b1;
          occ_d     = occ_q + CW'(1);
        end
      end
      OP_LINK_DOWN: begin
        if (hit_q) begin
          ok  = 1'b1;
          ent = '0;
          vld_d[hidx_q] = 1'b0;
          occ_d = occ_q - CW'(1);
          if (hent_q.st == ST_JOINED) begin
            joined_d = joined_q - CW'(1);
          end
        end
      end
      OP_MARK_JOINED: begin
        if (hit_q && (hent_q.st == ST_HANDSHAKING)) begin
          ok        = 1'b1;
          we        = 1'b1;
          ent.st    = ST_JOINED;
          ent.peer  = cur_q.peer;
          ent.minor = cur_q.minor;
          joined_d  = joined_q + CW'(1);
        end
      end
      OP_MARK_LEAVING: begin
        if (hit_q && (hent_q.st == ST_JOINED)) begin
          ok       = 1'b1;
          we       = 1'b1;
          ent.st   = ST_LEAVING;
          joined_d = joined_q - CW'(1);
        end
      end
      OP_FIND_LINK, OP_FIND_PEER: begin
        ok = hit_q;
      end
      default: ok = 1'b0;
    endcase

    if (!fire) begin
      we       = 1'b0;
      vld_d    = vld_q;
      joined_d = joined_q;
      occ_d    = occ_q;
    end

    out_d                = '0;
    out_d.joined_count   = 5'(joined_d);
    out_d.occupied_count = 5'(occ_d);
    if (ok) begin
      out_d.ok          = 1'b1;
      out_d.slot_index  = 4'(idx);
      out_d.slot_state  = ent.st;
      out_d.found_link  = ent.link;
      out_d.found_peer  = ent.peer;
      out_d.found_minor = ent.minor;
    end

    if (fire) begin
      out_valid_d = 1'b1;
    end else begin
      out_valid_d = out_valid_q && out_stall_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= BK_IDLE;
      vld_q       <= '0;
      cnt_q       <= '0;
      rdp_q       <= 1'b0;
      hit_q       <= 1'b0;
      free_q      <= 1'b0;
      joined_q    <= '0;
      occ_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      st_q        <= st_d;
      vld_q       <= vld_d;
      cnt_q       <= cnt_d;
      rdp_q       <= rdp_d;
      hit_q       <= hit_d;
      free_q      <= free_d;
      joined_q    <= joined_d;
      occ_q       <= occ_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q  <= cur_d;
    hidx_q <= hidx_d;
    hent_q <= hent_d;
    fidx_q <= fidx_d;
    rdi_q  <= cnt_q;
    rv_q   <= vld_q[cnt_q];
    if (fire) begin
      out_q <= out_d;
    end
  end

  // slot memory, one read and one write port
  always_ff @(posedge clk_i) begin
    rd_q <= mem[cnt_q];
    if (we) begin
      mem[idx] <= ent;
    end
  end

endmodule

FILE: hdl/peer_connection_table_unit.sv
// top level of the peer connection table
// sequence: idle, scan of every slot, drain, then exec, which writes the output
// register and waits while the output is stalled; one transaction at a time, set
// by the scan of the single read port slot memory; two commands queue ahead
// reset: all slots read as free at once through per-slot valid flags, no sweep
module peer_connection_table_unit #(
  parameter int SLOTS = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  pct_pkg::req_t in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output pct_pkg::rsp_t out_data_o
);
  import pct_pkg::*;

  logic cmd_valid;
  logic cmd_pop;
  cmd_t cmd;

  pct_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  pct_back #(
    .SLOTS (SLOTS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule
